// File: design/valve_pulse_sequencer_macros.svh
// assertion macros for the valve pulse sequencer
`ifndef VALVE_PULSE_SEQUENCER_MACROS_SVH
`define VALVE_PULSE_SEQUENCER_MACROS_SVH

// checked on every clock edge outside reset
`define VPS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every clock edge, reset included
`define VPS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: design/vps_pkg.sv
// shared types, constants and helpers of the valve pulse sequencer
package vps_pkg;

  localparam int NUM_VALVES = 16;
  localparam int TICK_MS    = 10;
  localparam int MS_PER_S   = 1000;
  localparam int CMP_W      = 16 + $clog2(TICK_MS + 1);

  localparam logic [15:0] USABLE_MASK = 16'((32'h1 << NUM_VALVES) - 1);

  localparam logic [7:0] REG_VALVE_MASK = 8'd0;
  localparam logic [7:0] REG_PULSE_MS   = 8'd1;
  localparam logic [7:0] REG_INTERVAL_S = 8'd2;
  localparam logic [7:0] REG_ROUNDS     = 8'd3;

  typedef struct packed {
    logic [15:0] valve_enable_mask;
    logic [8:0]  pulse_time_ms;
    logic [6:0]  interval_time_s;
    logic [6:0]  round_count;
  } cfg_t;

  typedef struct packed {
    logic [15:0] valve_drive;
    logic [3:0]  active_valve;
    logic [2:0]  phase_code;
    logic        report_pressure;
    logic        report_valve_state;
    logic        feedback_enable;
    logic [6:0]  rounds_left;
  } result_t;

  // index of the lowest set bit, 15 when bits 0 to 14 are all clear
  function automatic logic [3:0] lowest_set(logic [15:0] m);
    logic [3:0] idx;
    idx = 4'd15;
    for (int i = 15; i >= 0; i--) begin
      if (m[i]) idx = 4'(i);
    end
    return idx;
  endfunction

endpackage

// File: design/vps_cfg.sv
// configuration registers with range checks
module vps_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [7:0]    cfg_index_i,
  input  logic [15:0]   cfg_data_i,
  output vps_pkg::cfg_t cfg_o
);
  import vps_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;
  logic wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i && cfg_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      case (cfg_index_i)
        REG_VALVE_MASK: cfg_d.valve_enable_mask = cfg_data_i;
        REG_PULSE_MS: begin
          if (cfg_data_i[8:0] >= 9'd30 && cfg_data_i[8:0] <= 9'd300)
            cfg_d.pulse_time_ms = cfg_data_i[8:0];
        end
        REG_INTERVAL_S: begin
          if (cfg_data_i[6:0] >= 7'd1 && cfg_data_i[6:0] <= 7'd100)
            cfg_d.interval_time_s = cfg_data_i[6:0];
        end
        REG_ROUNDS: begin
          if (cfg_data_i[6:0] >= 7'd3 && cfg_data_i[6:0] <= 7'd100)
            cfg_d.round_count = cfg_data_i[6:0];
        end
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.valve_enable_mask <= 16'd0;
      cfg_q.pulse_time_ms     <= 9'd30;
      cfg_q.interval_time_s   <= 7'd1;
      cfg_q.round_count       <= 7'd3;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: design/vps_core.sv
// sequencer state and one-step next-state logic
module vps_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             start_req_i,
  input  logic             tick_i,
  input  vps_pkg::cfg_t    cfg_i,
  output vps_pkg::result_t result_o
);
  import vps_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_START    = 3'd1,
    PH_SELECT   = 3'd2,
    PH_PULSE    = 3'd3,
    PH_RELEASE  = 3'd4,
    PH_INTERVAL = 3'd5,
    PH_ROUND    = 3'd6,
    PH_END      = 3'd7
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] mask_q, mask_d;
  logic [6:0]  rounds_q, rounds_d;
  logic [3:0]  valve_q, valve_d;
  logic [15:0] pulse_ticks_q, pulse_ticks_d;
  logic [15:0] ival_ticks_q, ival_ticks_d;
  logic [15:0] drive_q, drive_d;
  logic        fb_q, fb_d;

  logic [15:0]      pulse_inc, ival_inc;
  logic [CMP_W-1:0] pulse_elapsed, ival_elapsed, ival_limit;
  logic [3:0]       sel_idx;
  logic             rep_p, rep_v;

  always_comb begin
    pulse_inc = pulse_ticks_q;
    if (tick_i && phase_q == PH_PULSE && pulse_ticks_q != 16'hFFFF)
      pulse_inc = pulse_ticks_q + 16'd1;
    ival_inc = ival_ticks_q;
    if (tick_i && phase_q == PH_INTERVAL && ival_ticks_q != 16'hFFFF)
      ival_inc = ival_ticks_q + 16'd1;
  end

  assign pulse_elapsed = CMP_W'(pulse_inc) * CMP_W'(TICK_MS);
  assign ival_elapsed  = CMP_W'(ival_inc) * CMP_W'(TICK_MS);
  assign ival_limit    = CMP_W'(cfg_i.interval_time_s) * CMP_W'(MS_PER_S);
  assign sel_idx       = lowest_set(mask_q);

  always_comb begin
    phase_d       = phase_q;
    mask_d        = mask_q;
    rounds_d      = rounds_q;
    valve_d       = valve_q;
    pulse_ticks_d = pulse_inc;
    ival_ticks_d  = ival_inc;
    drive_d       = drive_q;
    fb_d          = fb_q;
    rep_p         = 1'b0;
    rep_v         = 1'b0;
    case (phase_q)
      PH_IDLE: begin
        if (start_req_i) phase_d = PH_START;
      end
      PH_START: begin
        rounds_d = cfg_i.round_count;
        mask_d   = cfg_i.valve_enable_mask & USABLE_MASK;
        phase_d  = PH_SELECT;
      end
      PH_SELECT: begin
        if (mask_q == 16'd0) begin
          phase_d = PH_ROUND;
        end else begin
          mask_d        = mask_q & ~(16'd1 << sel_idx);
          valve_d       = sel_idx;
          drive_d       = drive_q | (16'd1 << sel_idx);
          rep_p         = 1'b1;
          pulse_ticks_d = 16'd0;
          phase_d       = PH_PULSE;
        end
      end
      PH_PULSE: begin
        rep_p = 1'b1;
        if (pulse_elapsed >= CMP_W'(cfg_i.pulse_time_ms)) begin
          pulse_ticks_d = 16'd0;
          phase_d       = PH_RELEASE;
        end
      end
      PH_RELEASE: begin
        rep_v        = 1'b1;
        drive_d      = drive_q & ~(16'd1 << valve_q);
        fb_d         = 1'b1;
        ival_ticks_d = 16'd0;
        phase_d      = PH_INTERVAL;
      end
      PH_INTERVAL: begin
        if (ival_elapsed >= ival_limit) begin
          ival_ticks_d = 16'd0;
          phase_d      = (mask_q == 16'd0) ? PH_ROUND : PH_SELECT;
        end
      end
      PH_ROUND: begin
        if (rounds_q > 7'd1) begin
          rounds_d = rounds_q - 7'd1;
          mask_d   = cfg_i.valve_enable_mask & USABLE_MASK;
          phase_d  = PH_SELECT;
        end else begin
          rounds_d = 7'd0;
          phase_d  = PH_END;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      mask_q        <= 16'd0;
      rounds_q      <= 7'd0;
      valve_q       <= 4'd0;
      pulse_ticks_q <= 16'd0;
      ival_ticks_q  <= 16'd0;
      drive_q       <= 16'd0;
      fb_q          <= 1'b0;
    end else if (step_i) begin
      phase_q       <= phase_d;
      mask_q        <= mask_d;
      rounds_q      <= rounds_d;
      valve_q       <= valve_d;
      pulse_ticks_q <= pulse_ticks_d;
      ival_ticks_q  <= ival_ticks_d;
      drive_q       <= drive_d;
      fb_q          <= fb_d;
    end
  end

  always_comb begin
    result_o.valve_drive        = drive_d;
    result_o.active_valve       = valve_d;
    result_o.phase_code         = phase_q;
    result_o.report_pressure    = rep_p;
    result_o.report_valve_state = rep_v;
    result_o.feedback_enable    = fb_d;
    result_o.rounds_left        = rounds_d;
  end

endmodule

// File: design/vps_out.sv
// result register between the step logic and the output channel
module vps_out (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  vps_pkg::result_t result_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output vps_pkg::result_t result_o
);
  import vps_pkg::*;

  logic    valid_q, valid_d;
  result_t data_q;
  logic    load;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) valid_d = 1'b1;
    else if (out_ready_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) data_q <= result_i;
  end

  assign out_valid_o = valid_q;
  assign result_o    = data_q;

endmodule

// File: design/valve_pulse_sequencer.sv
// top level of the valve pulse sequencer
//
//   channel | direction | handshake            | payload
//   cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//   in      | in        | in_valid/in_ready    | start_req, tick
//   out     | out       | out_valid/out_ready  | valve_drive .. rounds_left
//
// one step per cycle unless the output stalls: each input transaction runs one phase of the sequencer
// and its result is in the output register on the next cycle
// the output register sets the pace: input is stalled only while a result waits
// configuration writes are taken every cycle, cfg_ready is always high
// reset clears the sequencer to idle and the registers to their defaults
module valve_pulse_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        start_req_i,
  input  logic        tick_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] valve_drive_o,
  output logic [3:0]  active_valve_o,
  output logic [2:0]  phase_code_o,
  output logic        report_pressure_o,
  output logic        report_valve_state_o,
  output logic        feedback_enable_o,
  output logic [6:0]  rounds_left_o
);
  import vps_pkg::*;

  `include "valve_pulse_sequencer_macros.svh"

  cfg_t    cfg;
  result_t step_res;
  result_t out_res;
  logic    step;

  assign step = in_valid_i && in_ready_o;

  vps_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  vps_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .start_req_i (start_req_i),
    .tick_i      (tick_i),
    .cfg_i       (cfg),
    .result_o    (step_res)
  );

  vps_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .result_i    (step_res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_res)
  );

  assign valve_drive_o        = out_res.valve_drive;
  assign active_valve_o       = out_res.active_valve;
  assign phase_code_o         = out_res.phase_code;
  assign report_pressure_o    = out_res.report_pressure;
  assign report_valve_state_o = out_res.report_valve_state;
  assign feedback_enable_o    = out_res.feedback_enable;
  assign rounds_left_o        = out_res.rounds_left;

  `VPS_ASSERT(a_step_gives_result, step |=> out_valid_o, "accepted step produced no result")
  `VPS_ASSERT(a_one_coil, out_valid_o |-> $countones(valve_drive_o) <= 1, "more than one coil driven")
  `VPS_ASSERT(a_pressure_coil, out_valid_o && report_pressure_o |-> valve_drive_o[active_valve_o], "pressure report without the active coil on")
  `VPS_ASSERT(a_release_feedback, out_valid_o && report_valve_state_o |-> feedback_enable_o, "release without feedback enabled")

endmodule

// File: tb/sv/valve_sequence_checker.sv
// step predictor and result checker for the valve pulse sequencer
module valve_sequence_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [7:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        start_req_i,
  input  logic        tick_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [15:0] valve_drive_i,
  input  logic [3:0]  active_valve_i,
  input  logic [2:0]  phase_code_i,
  input  logic        report_pressure_i,
  input  logic        report_valve_state_i,
  input  logic        feedback_enable_i,
  input  logic [6:0]  rounds_left_i,
  output int unsigned mismatch_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import vps_pkg::*;

  localparam int PRINT_LIMIT = 40;

  typedef enum logic [2:0] {
    SEQ_IDLE     = 3'd0,
    SEQ_LOAD     = 3'd1,
    SEQ_SELECT   = 3'd2,
    SEQ_PULSE    = 3'd3,
    SEQ_RELEASE  = 3'd4,
    SEQ_INTERVAL = 3'd5,
    SEQ_ROUND    = 3'd6,
    SEQ_END      = 3'd7
  } seq_phase_e;

  cfg_t        regs;
  seq_phase_e  phase;
  logic [15:0] pending_valves;
  logic [6:0]  rounds_ctr;
  logic [3:0]  valve_idx;
  logic [15:0] pulse_ticks;
  logic [15:0] interval_ticks;
  logic [15:0] drive_bits;
  logic        feedback_seen;
  result_t     expected_steps[$];
  int unsigned mismatches = 0;

  assign mismatch_count_o = mismatches;

  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_LIMIT) begin
      $display("%0t: step mismatch, %s", $time, what);
    end
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  // out-of-range values leave the register unchanged
  function automatic void write_register(logic [7:0] index, logic [15:0] data);
    case (index)
      REG_VALVE_MASK: regs.valve_enable_mask = data;
      REG_PULSE_MS: begin
        if (data[8:0] >= 9'd30 && data[8:0] <= 9'd300) regs.pulse_time_ms = data[8:0];
      end
      REG_INTERVAL_S: begin
        if (data[6:0] >= 7'd1 && data[6:0] <= 7'd100) regs.interval_time_s = data[6:0];
      end
      REG_ROUNDS: begin
        if (data[6:0] >= 7'd3 && data[6:0] <= 7'd100) regs.round_count = data[6:0];
      end
      default: ;
    endcase
  endfunction

  function automatic result_t advance_sequence(logic start, logic tk);
    result_t    r;
    seq_phase_e handled;
    logic       pressure;
    logic       state_report;
    int         idx;
    handled      = phase;
    pressure     = 1'b0;
    state_report = 1'b0;
    if (tk) begin
      if (phase == SEQ_PULSE && pulse_ticks != 16'hFFFF) pulse_ticks = pulse_ticks + 16'd1;
      if (phase == SEQ_INTERVAL && interval_ticks != 16'hFFFF) begin
        interval_ticks = interval_ticks + 16'd1;
      end
    end
    case (handled)
      SEQ_IDLE: begin
        if (start) phase = SEQ_LOAD;
      end
      SEQ_LOAD: begin
        rounds_ctr     = regs.round_count;
        pending_valves = regs.valve_enable_mask & USABLE_MASK;
        phase          = SEQ_SELECT;
      end
      SEQ_SELECT: begin
        if (pending_valves == 16'h0000) begin
          phase = SEQ_ROUND;
        end else begin
          idx = 15;
          for (int b = 14; b >= 0; b--) begin
            if (pending_valves[b]) idx = b;
          end
          valve_idx                 = 4'(idx);
          pending_valves[valve_idx] = 1'b0;
          drive_bits[valve_idx]     = 1'b1;
          pressure                  = 1'b1;
          pulse_ticks               = 16'h0000;
          phase                     = SEQ_PULSE;
        end
      end
      SEQ_PULSE: begin
        pressure = 1'b1;
        if (int'(pulse_ticks) * TICK_MS >= int'(regs.pulse_time_ms)) begin
          pulse_ticks = 16'h0000;
          phase       = SEQ_RELEASE;
        end
      end
      SEQ_RELEASE: begin
        state_report          = 1'b1;
        drive_bits[valve_idx] = 1'b0;
        feedback_seen         = 1'b1;
        interval_ticks        = 16'h0000;
        phase                 = SEQ_INTERVAL;
      end
      SEQ_INTERVAL: begin
        if (int'(interval_ticks) * TICK_MS >= int'(regs.interval_time_s) * MS_PER_S) begin
          interval_ticks = 16'h0000;
          phase          = (pending_valves == 16'h0000) ? SEQ_ROUND : SEQ_SELECT;
        end
      end
      SEQ_ROUND: begin
        if (rounds_ctr > 7'd1) begin
          rounds_ctr     = rounds_ctr - 7'd1;
          pending_valves = regs.valve_enable_mask & USABLE_MASK;
          phase          = SEQ_SELECT;
        end else begin
          rounds_ctr = 7'd0;
          phase      = SEQ_END;
        end
      end
      default: phase = SEQ_IDLE;
    endcase
    r.valve_drive        = drive_bits;
    r.active_valve       = valve_idx;
    r.phase_code         = handled;
    r.report_pressure    = pressure;
    r.report_valve_state = state_report;
    r.feedback_enable    = feedback_seen;
    r.rounds_left        = rounds_ctr;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      regs           = '{valve_enable_mask: 16'h0000, pulse_time_ms: 9'd30,
                         interval_time_s: 7'd1, round_count: 7'd3};
      phase          = SEQ_IDLE;
      pending_valves = 16'h0000;
      rounds_ctr     = 7'd0;
      valve_idx      = 4'd0;
      pulse_ticks    = 16'h0000;
      interval_ticks = 16'h0000;
      drive_bits     = 16'h0000;
      feedback_seen  = 1'b0;
      expected_steps.delete();
    end else begin
      // result transaction against the oldest prediction
      if (out_valid_i && out_ready_i) begin
        if (expected_steps.size() == 0) begin
          report_mismatch($sformatf("result with phase %0d and no step pending",
                                    phase_code_i));
        end else begin
          want = expected_steps.pop_front();
          check_field("valve_drive", valve_drive_i, want.valve_drive);
          check_field("active_valve", 16'(active_valve_i), 16'(want.active_valve));
          check_field("phase_code", 16'(phase_code_i), 16'(want.phase_code));
          check_field("report_pressure", 16'(report_pressure_i),
                      16'(want.report_pressure));
          check_field("report_valve_state", 16'(report_valve_state_i),
                      16'(want.report_valve_state));
          check_field("feedback_enable", 16'(feedback_enable_i),
                      16'(want.feedback_enable));
          check_field("rounds_left", 16'(rounds_left_i), 16'(want.rounds_left));
        end
      end
      if (cfg_valid_i && cfg_ready_i) write_register(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_i) begin
        expected_steps.push_back(advance_sequence(start_req_i, tick_i));
      end
    end
  end

endmodule

// File: tb/sv/tb_valve_pulse_sequencer.sv
// testbench top: register writes, random sequencer steps and the final verdict
module tb_valve_pulse_sequencer;
  timeunit 1ns;
  timeprecision 1ps;
  import vps_pkg::*;

  localparam int         CLK_HALF         = 6;
  localparam int         RESET_CYCLES     = 12;
  localparam int         SINK_HOLD_CYCLES = 200;
  localparam int         WATCHDOG_LIMIT   = 2000;
  localparam int         TICK_PCT         = 94;
  localparam logic [7:0] REG_UNUSED_LOW   = 8'd4;
  localparam logic [7:0] REG_UNUSED_HIGH  = 8'hFF;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_valid   = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index   = 8'h00;
  logic [15:0] cfg_data    = 16'h0000;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  logic        start_req   = 1'b0;
  logic        tick        = 1'b0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  logic [15:0] valve_drive;
  logic [3:0]  active_valve;
  logic [2:0]  phase_code;
  logic        report_pressure;
  logic        report_valve_state;
  logic        feedback_enable;
  logic [6:0]  rounds_left;

  int unsigned mismatch_count;
  int unsigned steps_taken   = 0;
  int unsigned results_taken = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served  = 0;
  bit          steady        = 1'b0;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  valve_pulse_sequencer i_dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .start_req_i         (start_req),
    .tick_i              (tick),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .valve_drive_o       (valve_drive),
    .active_valve_o      (active_valve),
    .phase_code_o        (phase_code),
    .report_pressure_o   (report_pressure),
    .report_valve_state_o(report_valve_state),
    .feedback_enable_o   (feedback_enable),
    .rounds_left_o       (rounds_left)
  );

  valve_sequence_checker i_checker (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_i         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_ready_i          (in_ready),
    .start_req_i         (start_req),
    .tick_i              (tick),
    .out_valid_i         (out_valid),
    .out_ready_i         (out_ready),
    .valve_drive_i       (valve_drive),
    .active_valve_i      (active_valve),
    .phase_code_i        (phase_code),
    .report_pressure_i   (report_pressure),
    .report_valve_state_i(report_valve_state),
    .feedback_enable_i   (feedback_enable),
    .rounds_left_i       (rounds_left),
    .mismatch_count_o    (mismatch_count)
  );

  // transaction counters and watchdog
  always @(posedge clk) begin
    if (in_valid && in_ready) steps_taken <= steps_taken + 1;
    if (out_valid && out_ready) results_taken <= results_taken + 1;
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("valve_pulse_sequencer regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int idle_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result receiver with random stalls and one long hold on request
  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        out_ready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk);
        holds_served++;
      end
      gap = steady ? 0 : idle_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic send_step(input logic start, input logic tk);
    int gap;
    gap = steady ? 0 : idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    start_req <= start;
    tick      <= tk;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic run_steps(input int count, input int start_pct);
    repeat (count) begin
      send_step($urandom_range(0, 99) < start_pct, $urandom_range(0, 99) < TICK_PCT);
    end
  endtask

  // wait until every step transaction has its result
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_taken != steps_taken);
  endtask

  task automatic write_reg(input logic [7:0] index, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input logic [15:0] mask, input logic [15:0] pulse,
                           input logic [15:0] interval, input logic [15:0] rounds);
    settle();
    write_reg(REG_VALVE_MASK, mask);
    write_reg(REG_PULSE_MS, pulse);
    write_reg(REG_INTERVAL_S, interval);
    write_reg(REG_ROUNDS, rounds);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [15:0] mask;
    logic [15:0] pulse;
    logic [15:0] interval;
    logic [15:0] rounds;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // out-of-range values and unused indexes must leave the defaults in place
    write_reg(REG_PULSE_MS, 16'd29);
    write_reg(REG_PULSE_MS, 16'd301);
    write_reg(REG_INTERVAL_S, 16'd0);
    write_reg(REG_INTERVAL_S, 16'd101);
    write_reg(REG_ROUNDS, 16'd2);
    write_reg(REG_ROUNDS, 16'd101);
    write_reg(REG_UNUSED_HIGH, 16'hFFFF);
    write_reg(REG_UNUSED_LOW, 16'h00FF);
    cfg_valid <= 1'b0;

    // idle steps, then an empty-mask run with start held high outside idle
    send_step(1'b0, 1'b0);
    send_step(1'b0, 1'b1);
    repeat (10) send_step(1'b1, 1'($urandom_range(0, 1)));
    repeat (3) send_step(1'b0, 1'b1);

    // two valves at the shortest times, upper data bits set
    configure(16'h8001, 16'hFE1E, 16'hFF81, 16'h0003);
    steady = 1'b1;
    run_steps(40, 20);
    steady = 1'b0;
    run_steps(90, 20);

    // empty mask lets the running sequence finish its rounds
    configure(16'h0000, 16'd30, 16'd1, 16'd3);
    run_steps(75, 20);

    // longest times, all valves, most rounds, with a long receiver stall
    configure(16'hFFFF, 16'd300, 16'd100, 16'd100);
    hold_requests++;
    run_steps(50, 30);

    configure(16'hFFFF, 16'd30, 16'd1, 16'd100);
    run_steps(100, 30);

    repeat (4) begin
      case ($urandom_range(0, 2))
        0:       mask = 16'h0000;
        1:       mask = 16'(1) << $urandom_range(0, 15);
        default: mask = 16'($urandom());
      endcase
      pulse    = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(30, 300));
      interval = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'd1;
      rounds   = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(3, 100));
      configure(mask, pulse, interval, rounds);
      run_steps(20, 25);
    end

    settle();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("valve_pulse_sequencer regression: pass");
    end else begin
      $display("valve_pulse_sequencer regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/vps_pkg.sv
design/vps_cfg.sv
design/vps_core.sv
design/vps_out.sv
design/valve_pulse_sequencer.sv
tb/sv/valve_sequence_checker.sv
tb/sv/tb_valve_pulse_sequencer.sv
